/* src/dqpd_pkg.sv */
// Shared types and codes for the deque with positional delete.
`timescale 1ns / 1ps

package dqpd_pkg;

	// Default size of the node pool.
	localparam int DQPD_DEPTH_DEF = 64;

	// Request codes.
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_DELETE_AT  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One request transaction.
	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
		logic [9:0]         position;
	} dqpd_req_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [6:0]         entry_count;
	} dqpd_rsp_t;

endpackage

/* src/dqpd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module dqpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/deque_with_positional_delete.sv */
// Deque of signed 32-bit values kept as a doubly linked list in a node pool.
// A delete at a position follows the links through the next-pointer memory.
// One transaction is processed at a time; a new one is taken while a result still waits.
// Reset clears head, tail, count and the free-stack fill mark; the node
// memories need no clearing pass.
`timescale 1ns / 1ps

module deque_with_positional_delete
	import dqpd_pkg::*;
#(
	parameter int DEPTH = DQPD_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dqpd_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output dqpd_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(DEPTH + 1);
	localparam int CW = (IW > 10) ? IW : 10;
	localparam logic [IW-1:0] NIL = IW'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_ALLOC,
		S_LINK1,
		S_LINK2,
		S_WALK_RD,
		S_WALK_WT,
		S_FETCH,
		S_UNLINK,
		S_FINISH
	} state_t;

	state_t state_q;

	// Latched request.
	logic [2:0]  type_q;
	logic [31:0] val_q;
	logic [9:0]  pos_q;

	// List bookkeeping.
	logic [IW-1:0] head_q, tail_q, held_q, hwm_q;
	logic [IW-1:0] node_q, cur_q;
	logic [9:0]    cnt_q;
	logic [1:0]    status_q;
	logic [31:0]   removed_q;

	// Memory ports.
	logic          val_we, next_we, prev_we, free_we;
	logic [AW-1:0] val_waddr, next_waddr, prev_waddr, free_waddr;
	logic [AW-1:0] next_raddr, tgt_raddr, free_raddr;
	logic [31:0]   val_wdata, val_rdata;
	logic [IW-1:0] next_wdata, next_rdata, prev_wdata, prev_rdata;
	logic [AW-1:0] free_wdata, free_rdata;

	// Derived values.
	logic          is_back, is_push, is_remove, empty, full;
	logic          head_ok, tail_ok, cur_ok, p_ok, q_ok;
	logic [IW-1:0] held_dec;
	logic [CW-1:0] pos_ext, held_ext;
	logic [IW+6:0] count_ext;

	assign is_back   = (type_q == REQ_PUSH_BACK);
	assign is_push   = (type_q == REQ_PUSH_BACK) || (type_q == REQ_PUSH_FRONT);
	assign is_remove = (type_q == REQ_POP_BACK) || (type_q == REQ_POP_FRONT)
		|| (type_q == REQ_DELETE_AT);
	assign head_ok   = (head_q < NIL);
	assign tail_ok   = (tail_q < NIL);
	assign cur_ok    = (cur_q < NIL);
	assign p_ok      = (prev_rdata < NIL);
	assign q_ok      = (next_rdata < NIL);
	assign empty     = (held_q == '0) || !head_ok || !tail_ok;
	assign full      = (held_q >= NIL);
	assign held_dec  = held_q - 1'b1;
	assign pos_ext   = CW'(pos_q);
	assign held_ext  = CW'(held_q);
	assign count_ext = {7'b0, held_q};

	// Read addresses: the walk reads links at the cursor, the unlink reads the target.
	assign next_raddr = (state_q == S_WALK_RD) ? cur_q[AW-1:0] : node_q[AW-1:0];
	assign tgt_raddr  = node_q[AW-1:0];
	assign free_raddr = held_q[AW-1:0];

	// Write ports for linking, unlinking and returning a node to the free stack.
	always_comb begin
		val_we     = 1'b0;
		val_waddr  = node_q[AW-1:0];
		val_wdata  = val_q;
		next_we    = 1'b0;
		next_waddr = node_q[AW-1:0];
		next_wdata = NIL;
		prev_we    = 1'b0;
		prev_waddr = node_q[AW-1:0];
		prev_wdata = NIL;
		free_we    = 1'b0;
		free_waddr = held_dec[AW-1:0];
		free_wdata = node_q[AW-1:0];
		unique case (state_q)
			S_LINK1: begin
				val_we  = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
				if (is_back) begin
					next_wdata = NIL;
					prev_wdata = tail_q;
				end else begin
					next_wdata = head_q;
					prev_wdata = NIL;
				end
			end
			S_LINK2: begin
				if (is_back) begin
					next_we    = tail_ok;
					next_waddr = tail_q[AW-1:0];
					next_wdata = node_q;
				end else begin
					prev_we    = head_ok;
					prev_waddr = head_q[AW-1:0];
					prev_wdata = node_q;
				end
			end
			S_UNLINK: begin
				next_we    = p_ok;
				next_waddr = prev_rdata[AW-1:0];
				next_wdata = next_rdata;
				prev_we    = q_ok;
				prev_waddr = next_rdata[AW-1:0];
				prev_wdata = prev_rdata;
				free_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	// Sequencer, list registers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= NIL;
			tail_q    <= NIL;
			held_q    <= '0;
			hwm_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			// The result is raised when issued and dropped once it has been taken.
			if (state_q == S_FINISH && (!rsp_valid || !rsp_stall)) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q  <= req.req_type;
						val_q   <= req.value;
						pos_q   <= req.position;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q  <= ST_OK;
					removed_q <= '0;
					priority if (is_push) begin
						if (full) begin
							status_q <= ST_FULL;
							state_q  <= S_FINISH;
						end else if (held_q < hwm_q) begin
							state_q <= S_ALLOC;
						end else begin
							// At or above the fill mark the free stack is bypassed: node held_q has never been used.
							node_q  <= held_q;
							state_q <= S_LINK1;
						end
					end else if (is_remove) begin
						if (empty) begin
							status_q <= ST_EMPTY;
							state_q  <= S_FINISH;
						end else if (type_q == REQ_POP_BACK) begin
							node_q  <= tail_q;
							state_q <= S_FETCH;
						end else if (type_q == REQ_POP_FRONT || pos_q <= 10'd1) begin
							node_q  <= head_q;
							state_q <= S_FETCH;
						end else if (pos_ext >= held_ext) begin
							node_q  <= tail_q;
							state_q <= S_FETCH;
						end else begin
							cur_q   <= head_q;
							cnt_q   <= 10'd1;
							state_q <= S_WALK_RD;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_ALLOC: begin
					node_q  <= IW'(free_rdata);
					state_q <= S_LINK1;
				end
				S_LINK1: begin
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					if (is_back) begin
						if (!tail_ok) begin
							head_q <= node_q;
						end
						tail_q <= node_q;
					end else begin
						if (!head_ok) begin
							tail_q <= node_q;
						end
						head_q <= node_q;
					end
					held_q <= held_q + 1'b1;
					if (held_q >= hwm_q) begin
						hwm_q <= held_q + 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_WALK_RD: begin
					// Follow one next link per pass through the read and wait states until the position is reached.
					if (cnt_q < pos_q && cur_ok) begin
						state_q <= S_WALK_WT;
					end else begin
						node_q  <= cur_ok ? cur_q : tail_q;
						state_q <= S_FETCH;
					end
				end
				S_WALK_WT: begin
					cur_q   <= next_rdata;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_WALK_RD;
				end
				S_FETCH: begin
					state_q <= S_UNLINK;
				end
				S_UNLINK: begin
					if (!p_ok) begin
						head_q <= next_rdata;
					end
					if (!q_ok) begin
						tail_q <= prev_rdata;
					end
					removed_q <= val_rdata;
					held_q    <= held_dec;
					state_q   <= S_FINISH;
				end
				S_FINISH: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp.status        <= status_q;
						rsp.removed_value <= removed_q;
						rsp.entry_count   <= count_ext[6:0];
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Node pool memories and the free stack.
	dqpd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (tgt_raddr),
		.rdata (val_rdata)
	);

	dqpd_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (next_raddr),
		.rdata (next_rdata)
	);

	dqpd_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (tgt_raddr),
		.rdata (prev_rdata)
	);

	dqpd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

endmodule

/* bench/deque_with_positional_delete_tb.sv */
// Self-checking testbench for the deque with positional delete.
`timescale 1ns / 1ps

module deque_with_positional_delete_tb;
	import dqpd_pkg::*;

	localparam int POOL_DEPTH = DQPD_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_WAIT = 12;
	// Request codes that the block must ignore.
	localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;
	localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic [9:0] POS_MAX = 10'd1023;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	dqpd_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	dqpd_rsp_t rsp;

	// Predicted contents of the deque, front at index zero.
	logic signed [31:0] deque_contents[$];
	// Results predicted for accepted requests, oldest first.
	dqpd_rsp_t pending_results[$];
	int fail_count = 0;
	int requests_sent = 0;
	bit req_idle = 1'b0;
	bit rsp_idle = 1'b0;

	deque_with_positional_delete #(
		.DEPTH(POOL_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Number of idle cycles before the next transaction on one side.
	function automatic int draw_wait(input bit idle_on);
		return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	// Apply one request to the predicted deque and return the result it gives.
	function automatic dqpd_rsp_t apply_request(input dqpd_req_t r);
		dqpd_rsp_t outcome;
		int len;
		int slot;
		outcome = '0;
		outcome.status = ST_OK;
		len = deque_contents.size();
		case (r.req_type)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (len >= POOL_DEPTH) begin
					outcome.status = ST_FULL;
				end else if (r.req_type == REQ_PUSH_BACK) begin
					deque_contents.push_back(r.value);
				end else begin
					deque_contents.push_front(r.value);
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT, REQ_DELETE_AT: begin
				if (len == 0) begin
					outcome.status = ST_EMPTY;
				end else begin
					// Positions at or below one hit the front, past the end the back.
					if (r.req_type == REQ_POP_BACK) begin
						slot = len - 1;
					end else if (r.req_type == REQ_POP_FRONT || r.position <= 1) begin
						slot = 0;
					end else if (int'(r.position) >= len) begin
						slot = len - 1;
					end else begin
						slot = int'(r.position) - 1;
					end
					outcome.removed_value = deque_contents[slot];
					deque_contents.delete(slot);
				end
			end
			default: begin
			end
		endcase
		outcome.entry_count = 7'(deque_contents.size());
		return outcome;
	endfunction

	// A delete position aimed at the interesting spots of the current list.
	function automatic logic [9:0] pick_position();
		int len;
		len = deque_contents.size();
		case ($urandom_range(0, 6))
			0: return 10'd0;
			1: return 10'd1;
			2: return 10'(len);
			3: return 10'(len + 1);
			4: return 10'($urandom_range(0, POS_MAX));
			default: return 10'($urandom_range(2, (len < 2) ? 2 : len));
		endcase
	endfunction

	// A value that is often one of the extremes.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// Offer one request transaction and record its prediction once accepted.
	task automatic send_request(input logic [2:0] kind, input logic signed [31:0] val,
			input logic [9:0] pos);
		dqpd_req_t item;
		int gap;
		item.req_type = kind;
		item.value = val;
		item.position = pos;
		gap = draw_wait(req_idle);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		pending_results.push_back(apply_request(item));
		requests_sent++;
	endtask

	// Pops and deletes on an empty list, and unused codes.
	task automatic test_empty_requests();
		req_idle = 1'b0;
		rsp_idle = 1'b0;
		send_request(REQ_POP_BACK, VALUE_MAX, 10'd0);
		send_request(REQ_POP_FRONT, VALUE_MIN, 10'd0);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd0);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd1);
		send_request(REQ_DELETE_AT, -32'sd1, POS_MAX);
		send_request(REQ_UNUSED_LO, VALUE_MAX, POS_MAX);
		send_request(REQ_UNUSED_HI, -32'sd1, POS_MAX);
	endtask

	// Pushes and pops at both ends with the extreme values.
	task automatic test_push_pop_ends();
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		send_request(REQ_PUSH_BACK, VALUE_MAX, POS_MAX);
		send_request(REQ_PUSH_FRONT, VALUE_MIN, 10'd0);
		send_request(REQ_PUSH_BACK, -32'sd1, 10'd0);
		send_request(REQ_UNUSED_MID, 32'sd5, 10'd3);
		send_request(REQ_POP_FRONT, 32'sd0, 10'd0);
		send_request(REQ_POP_BACK, 32'sd0, 10'd0);
		send_request(REQ_POP_BACK, 32'sd0, 10'd0);
	endtask

	// Deletes at the front, in the middle, at the end and past the end.
	task automatic test_positional_delete();
		req_idle = 1'b0;
		rsp_idle = 1'b1;
		for (int k = 0; k < 6; k++) begin
			send_request(REQ_PUSH_BACK, 32'sd100 + k, 10'd0);
		end
		send_request(REQ_DELETE_AT, 32'sd0, 10'd0);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd2);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd3);
		send_request(REQ_DELETE_AT, 32'sd0, POS_MAX);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd2);
		send_request(REQ_DELETE_AT, 32'sd0, 10'd1);
	endtask

	// Random phases: fill to overflow, drain past empty, mixed traffic and noise.
	task automatic test_random_traffic();
		int start;
		int pick;
		start = requests_sent;
		while (requests_sent - start < RANDOM_ITEMS) begin
			req_idle = ($urandom_range(0, 3) != 0);
			rsp_idle = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: begin
					// Grow until the pool is full, then push into the full pool.
					while (deque_contents.size() < POOL_DEPTH) begin
						pick = $urandom_range(0, 9);
						if (pick < 4) begin
							send_request(REQ_PUSH_BACK, pick_value(), pick_position());
						end else if (pick < 8) begin
							send_request(REQ_PUSH_FRONT, pick_value(), pick_position());
						end else if (pick == 8) begin
							send_request(REQ_DELETE_AT, pick_value(), pick_position());
						end else begin
							send_request(REQ_POP_FRONT, pick_value(), pick_position());
						end
					end
					repeat ($urandom_range(1, 3)) begin
						send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
							pick_value(), pick_position());
					end
				end
				1: begin
					// Shrink until empty, then ask for more than is there.
					while (deque_contents.size() > 0) begin
						pick = $urandom_range(0, 9);
						if (pick < 2) begin
							send_request(REQ_POP_BACK, pick_value(), pick_position());
						end else if (pick < 4) begin
							send_request(REQ_POP_FRONT, pick_value(), pick_position());
						end else if (pick < 9) begin
							send_request(REQ_DELETE_AT, pick_value(), pick_position());
						end else begin
							send_request(REQ_PUSH_BACK, pick_value(), pick_position());
						end
					end
					repeat ($urandom_range(1, 2)) begin
						send_request(REQ_DELETE_AT - 3'($urandom_range(0, 2)), pick_value(),
							pick_position());
					end
				end
				2: begin
					// Well-formed requests of every kind around the current length.
					repeat (40) begin
						send_request(3'($urandom_range(REQ_PUSH_BACK, REQ_DELETE_AT)),
							pick_value(), pick_position());
					end
				end
				default: begin
					// Unconstrained fields, unused codes included.
					repeat (15) begin
						send_request(3'($urandom_range(REQ_PUSH_BACK, REQ_UNUSED_HI)),
							$urandom(), 10'($urandom_range(0, POS_MAX)));
					end
				end
			endcase
		end
	endtask

	// Result checking: each result transaction against the oldest prediction.
	initial begin
		dqpd_rsp_t want;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait(rsp_idle);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, rsp.status);
					fail_count++;
				end
				if (rsp.removed_value !== want.removed_value) begin
					$display("%0t: removed_value mismatch, expected %0d, actual %0d",
						$time, want.removed_value, rsp.removed_value);
					fail_count++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$display("%0t: entry_count mismatch, expected %0d, actual %0d",
						$time, want.entry_count, rsp.entry_count);
					fail_count++;
				end
			end
		end
	end

	// Stimulus sequence and end of run.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_requests();
		test_push_pop_ends();
		test_positional_delete();
		test_random_traffic();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * POOL_DEPTH + 20) @(posedge clk);
		if (fail_count == 0) begin
			$display("deque_with_positional_delete_tb: PASS");
		end else begin
			$display("deque_with_positional_delete_tb: FAIL");
		end
		$finish;
	end

	// Watchdog in case the block stops answering.
	initial begin
		#5_000_000;
		$display("deque_with_positional_delete_tb: FAIL");
		$finish;
	end

endmodule
